>>> hdl/chm_pkg.sv
// Shared types and constants for the chained hash map engine.
package chm_pkg;

  localparam int unsigned BUCKETS_DEF = 64;
  localparam int unsigned NODES_DEF   = 128;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_FIND   = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  // Request after classification by the front end.
  typedef struct packed {
    logic               is_op;
    func_t              func;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

endpackage

>>> hdl/chm_if.sv
// Valid/ready channel interfaces for requests and results.
interface chm_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] key;
  logic signed [31:0] value_in;
  modport source (output valid, func, key, value_in, input ready);
  modport sink   (input valid, func, key, value_in, output ready);
endinterface

interface chm_rsp_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic signed [31:0] value_out;
  logic               status;
  logic [7:0]         entry_count;
  modport source (output valid, found, value_out, status, entry_count, input ready);
  modport sink   (input valid, found, value_out, status, entry_count, output ready);
endinterface

>>> hdl/chm_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module chm_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  output logic          req_ready,
  input  logic [1:0]    req_func,
  input  logic [31:0]   req_key,
  input  logic [31:0]   req_value,
  output logic          q_valid,
  input  logic          q_pop,
  output chm_pkg::req_t q_head
);

  localparam int unsigned D  = chm_pkg::QUEUE_DEPTH;
  localparam int unsigned AW = $clog2(D);

  chm_pkg::req_t       mem_r [D];
  logic [AW-1:0]       wp_r, rp_r;
  logic [AW:0]         cnt_r;
  chm_pkg::req_t       item;
  logic                push;

  assign req_ready = (cnt_r != D[AW:0]);
  assign push      = req_valid && req_ready;
  assign q_valid   = (cnt_r != '0);
  assign q_head    = mem_r[rp_r];

  always_comb begin
    item.func  = chm_pkg::func_t'(req_func);
    item.is_op = (req_func != chm_pkg::FUNC_NOP);
    item.key   = req_key;
    item.value = req_value;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(D - 1)) ? '0 : wp_r + 1'b1;
      end
      if (q_pop) begin
        rp_r <= (rp_r == AW'(D - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(q_pop);
    end
  end

endmodule

>>> hdl/chm_back.sv
// Back end: walks the bucket chain in the node memories and applies the request.
module chm_back #(
  parameter int unsigned BUCKETS = chm_pkg::BUCKETS_DEF,
  parameter int unsigned NODES   = chm_pkg::NODES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_pop,
  input  chm_pkg::req_t q_head,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output logic          rsp_found,
  output logic [31:0]   rsp_value,
  output logic          rsp_status,
  output logic [7:0]    rsp_count,
  output logic          busy
);

  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned CW = $clog2(NODES + 1);
  localparam int unsigned SW = (BUCKETS > NODES) ? $clog2(BUCKETS + 1) : $clog2(NODES + 1);

  typedef enum logic [7:0] {
    ST_INIT  = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_HEAD  = 8'b0000_0100,
    ST_READ  = 8'b0000_1000,
    ST_CMP   = 8'b0001_0000,
    ST_FREE  = 8'b0010_0000,
    ST_DONE  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Bucket heads: memory, cleared by a sweep after reset.
  logic [NW:0]   bhead_mem [BUCKETS];   // {live, node}
  logic [31:0]   nkey_mem  [NODES];
  logic [31:0]   nval_mem  [NODES];
  logic [NW:0]   nnext_mem [NODES];     // {link, node}

  logic [NW:0]   bh_rd_r, nn_rd_r;
  logic [31:0]   nk_rd_r, nv_rd_r;

  chm_pkg::req_t req_r;
  logic [BW-1:0] bucket_r;
  logic [NW-1:0] cur_r, prev_r, free_r;
  logic          has_prev_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] steps_r;
  logic [SW-1:0] init_r;
  logic          found_r, status_r;
  logic [31:0]   vout_r;

  // memory port controls
  logic          bh_we;  logic [BW-1:0] bh_wa;  logic [NW:0] bh_wd;
  logic          nn_we;  logic [NW-1:0] nn_wa;  logic [NW:0] nn_wd;
  logic          nk_we, nv_we; logic [NW-1:0] kv_wa; logic [31:0] nv_wd;
  logic [NW-1:0] n_ra;
  logic [BW-1:0] b_ra;

  logic hit, full;
  assign hit  = (nk_rd_r == req_r.key);
  assign full = (count_r >= CW'(NODES));

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (bh_we) bhead_mem[bh_wa] <= bh_wd;
    bh_rd_r <= bhead_mem[b_ra];
  end
  always_ff @(posedge clk) begin
    if (nn_we) nnext_mem[nn_wa] <= nn_wd;
    nn_rd_r <= nnext_mem[n_ra];
  end
  always_ff @(posedge clk) begin
    if (nk_we) nkey_mem[kv_wa] <= req_r.key;
    nk_rd_r <= nkey_mem[n_ra];
  end
  always_ff @(posedge clk) begin
    if (nv_we) nval_mem[kv_wa] <= nv_wd;
    nv_rd_r <= nval_mem[n_ra];
  end

  always_comb begin
    state_nxt = state_r;
    q_pop = 1'b0;
    bh_we = 1'b0; bh_wa = bucket_r; bh_wd = '0;
    nn_we = 1'b0; nn_wa = cur_r;    nn_wd = '0;
    nk_we = 1'b0; nv_we = 1'b0; kv_wa = cur_r; nv_wd = req_r.value;
    n_ra  = cur_r;
    // queue head while idle, else keep the bucket of the request in flight
    b_ra  = (state_r == ST_IDLE) ? q_head.key[BW-1:0] : bucket_r;
    case (state_r)
      ST_INIT: begin
        // sweep: clear bucket heads and chain the free list
        bh_we = (init_r < SW'(BUCKETS));
        bh_wa = init_r[BW-1:0];
        nn_we = (init_r < SW'(NODES));
        nn_wa = init_r[NW-1:0];
        nn_wd = {(init_r + 1'b1) < SW'(NODES), NW'(init_r + 1'b1)};
        if ((init_r + 1'b1 >= SW'(NODES)) && (init_r + 1'b1 >= SW'(BUCKETS)))
          state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          state_nxt = q_head.is_op ? ST_HEAD : ST_OUT;
        end
      end
      ST_HEAD: begin
        // bucket head read data available next
        state_nxt = ST_READ;
      end
      ST_READ: begin
        if (!bh_rd_r[NW]) state_nxt = ST_DONE;
        else begin
          n_ra = bh_rd_r[NW-1:0];
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (hit) state_nxt = ST_DONE;
        else if (!nn_rd_r[NW] || (steps_r + 1'b1 >= CW'(NODES))) state_nxt = ST_DONE;
        else begin
          n_ra = nn_rd_r[NW-1:0];
          state_nxt = ST_CMP;
        end
      end
      ST_DONE: begin
        // hit held in found_r; cur_r valid unless the bucket was empty
        state_nxt = ST_OUT;
        n_ra = free_r;
        case (req_r.func)
          chm_pkg::FUNC_INSERT: begin
            if (found_r) begin
              nv_we = 1'b1;
            end else if (!full) begin
              kv_wa = free_r; nk_we = 1'b1; nv_we = 1'b1;
              nn_we = 1'b1; nn_wa = free_r; nn_wd = bh_rd_r;
              bh_we = 1'b1; bh_wd = {1'b1, free_r};
              state_nxt = ST_FREE;
            end
          end
          chm_pkg::FUNC_REMOVE: begin
            if (found_r) begin
              if (has_prev_r) begin
                nn_we = 1'b1; nn_wa = prev_r; nn_wd = nn_rd_r;
              end else begin
                bh_we = 1'b1; bh_wd = nn_rd_r;
              end
              state_nxt = ST_FREE;
            end
          end
          default: ;
        endcase
      end
      ST_FREE: begin
        // insert: wait for next-of-free read; remove: link cur to free list
        if (req_r.func == chm_pkg::FUNC_REMOVE) begin
          nn_we = 1'b1; nn_wa = cur_r; nn_wd = {~full, free_r};
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (rsp_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (q_valid) begin
        req_r <= q_head; bucket_r <= q_head.key[BW-1:0];
        has_prev_r <= 1'b0; steps_r <= '0; found_r <= 1'b0;
        vout_r <= '0; status_r <= 1'b0;
      end
      ST_READ: if (bh_rd_r[NW]) cur_r <= bh_rd_r[NW-1:0];
      ST_CMP: begin
        if (hit) begin
          found_r <= 1'b1;
          if (req_r.func == chm_pkg::FUNC_FIND) vout_r <= nv_rd_r;
        end else if (nn_rd_r[NW] && (steps_r + 1'b1 < CW'(NODES))) begin
          prev_r <= cur_r; has_prev_r <= 1'b1;
          cur_r <= nn_rd_r[NW-1:0]; steps_r <= steps_r + 1'b1;
        end
      end
      ST_DONE: if (req_r.func == chm_pkg::FUNC_INSERT && !found_r && full)
        status_r <= 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      init_r  <= '0;
      free_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_INIT) init_r <= init_r + 1'b1;
      if (state_r == ST_FREE) begin
        if (req_r.func == chm_pkg::FUNC_REMOVE) begin
          free_r <= cur_r; count_r <= count_r - 1'b1;
        end else begin
          free_r <= nn_rd_r[NW-1:0]; count_r <= count_r + 1'b1;
        end
      end
    end
  end

  assign rsp_valid  = (state_r == ST_OUT);
  assign rsp_found  = found_r && req_r.is_op;
  assign rsp_value  = req_r.is_op ? vout_r : '0;
  assign rsp_status = status_r && req_r.is_op;
  assign rsp_count  = 8'(count_r);

endmodule

>>> hdl/chained_hash_map_engine_top.sv
// Top level of the chained hash map engine.
// One request (insert, find, remove) at a time; after it leaves the queue a
// request passes through ST_HEAD and ST_READ, then ST_CMP once for each chain
// node compared, each compare fed by one node-memory read, then ST_DONE and
// ST_OUT, where its result is offered; an insert that links a new node and a
// remove that finds its key also pass through ST_FREE, and an unused operation
// code goes straight to ST_OUT. A two-entry request queue decouples the input
// from the walk. After reset a clearing pass initializes bucket heads and
// the free list; requests queue up but are not executed until it ends.
// Results are offered in order and held until taken.
module chained_hash_map_engine_top #(
  parameter int unsigned BUCKETS = chm_pkg::BUCKETS_DEF,
  parameter int unsigned NODES   = chm_pkg::NODES_DEF
) (
  input logic clk,
  input logic rst_n,
  chm_req_if.sink   in_req,
  chm_rsp_if.source out_rsp
);

  logic          q_valid, q_pop, busy;
  chm_pkg::req_t q_head;

  chm_front u_front (
    .clk, .rst_n,
    .req_valid (in_req.valid), .req_ready (in_req.ready),
    .req_func (in_req.func), .req_key (in_req.key), .req_value (in_req.value_in),
    .q_valid, .q_pop, .q_head
  );

  chm_back #(.BUCKETS(BUCKETS), .NODES(NODES)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_head,
    .rsp_valid (out_rsp.valid), .rsp_ready (out_rsp.ready),
    .rsp_found (out_rsp.found), .rsp_value (out_rsp.value_out),
    .rsp_status (out_rsp.status), .rsp_count (out_rsp.entry_count),
    .busy
  );

  // pop only when the back end is idle and the queue holds a request
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_valid && !busy)) else $error("pop while busy or empty");
  // count never exceeds pool size
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid |-> (out_rsp.entry_count <= 8'(NODES))) else $error("count overflow");
  // refused insert never reports found
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && out_rsp.status |-> !out_rsp.found) else $error("status with found");

endmodule
